// ===== rtl/knnsel_pkg.sv =====
// Shared types and constants for the nearest-neighbour top-k select block.
// Holds the item structs, field widths and configuration register indexes.
// No dependencies.
package knnsel_pkg;

  localparam int ID_W       = 16;
  localparam int COORD_W    = 24;
  localparam int RANGE_W    = 23;
  localparam int WANT_W     = 4;
  localparam int DIST_W     = 46;
  localparam int RANK_W     = 3;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int DEF_MAX_KEPT = 8;
  localparam int DEF_ID_BITS  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_QUERY_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Z      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_ID     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RANGE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_COUNT = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]           candidate_id;
    logic signed [COORD_W-1:0] candidate_x;
    logic signed [COORD_W-1:0] candidate_z;
    logic                      final_candidate;
  } cand_t;

  typedef struct packed {
    logic [ID_W-1:0]   neighbour_id;
    logic [DIST_W-1:0] neighbour_dist_sq;
    logic [RANK_W-1:0] neighbour_rank;
    logic              entry_valid;
    logic              last_of_list;
  } nbr_t;

  // status of the distance pipeline's last stage
  typedef struct packed {
    logic valid;           // an item sits in the last stage
    logic keep;            // it passed the id and range filters
    logic fin;             // it is the last candidate of the query
    logic final_inflight;  // a final item is somewhere in the pipeline
  } dist_stat_t;

  typedef struct packed {
    logic shift_left;      // drain: every cell takes its right neighbor
    logic cand_valid;      // a candidate is offered to the chain
    logic trim;            // an item is handled: slots past the wanted count empty
  } cell_ctl_t;

endpackage

// ===== rtl/nearest_neighbour_top_k_select_core.sv =====
// Top level of the nearest-neighbour top-k select block: configuration
// registers, distance pipeline, insertion chain and result drain.
// Depends on knnsel_pkg, knnsel_dist and knnsel_cell.
//
//   channel  handshake               payload                  dir
//   cand     cand_valid/cand_ready   cand (cand_t)            in
//   nbr      nbr_valid/nbr_ready     nbr (nbr_t)              out
//   cfg      cfg_valid/cfg_ready     cfg_index, cfg_data      in
//
// Non-final candidates are taken one per cycle through a three-stage distance
// pipeline into the chain. A final candidate reaches the chain through stages
// s1, s2 and s3; the list then drains one result per cycle as nbr_ready allows,
// and no candidate is taken from the final one until the drain ends.
// Results wait in an output register, so nbr_ready low only pauses the drain.
// Reset clears the configuration registers, the chain's valid bits and all
// control state; no clearing pass is needed.
module nearest_neighbour_top_k_select_core import knnsel_pkg::*; #(
  parameter int MAX_KEPT = DEF_MAX_KEPT,
  parameter int ID_BITS  = DEF_ID_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cand_valid,
  output logic                  cand_ready,
  input  cand_t                 cand,
  output logic                  nbr_valid,
  input  logic                  nbr_ready,
  output nbr_t                  nbr,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IdW = (ID_BITS < ID_W) ? ID_BITS : ID_W;

  localparam logic ST_INSERT = 1'b0;
  localparam logic ST_DRAIN  = 1'b1;

  logic signed [COORD_W-1:0] query_x, query_z;
  logic [ID_W-1:0]           query_id;
  logic [RANGE_W-1:0]        search_range;
  logic [WANT_W-1:0]         wanted_count;

  logic              state, state_next;
  logic [RANK_W-1:0] rank;
  logic              load, last;
  nbr_t              nbr_next;

  dist_stat_t        stat;
  logic [IdW-1:0]    s3_id;
  logic [DIST_W-1:0] s3_dist;
  cell_ctl_t         ctl;

  logic [MAX_KEPT-1:0] cv, cb;
  logic [MAX_KEPT:0]   cv_pad;
  logic [IdW-1:0]      cid [MAX_KEPT];
  logic [DIST_W-1:0]   cdist [MAX_KEPT];

  // ---- configuration ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x      <= '0;
      query_z      <= '0;
      query_id     <= '0;
      search_range <= '0;
      wanted_count <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_QUERY_X:      query_x      <= cfg_data[COORD_W-1:0];
        REG_QUERY_Z:      query_z      <= cfg_data[COORD_W-1:0];
        REG_QUERY_ID:     query_id     <= cfg_data[ID_W-1:0];
        REG_SEARCH_RANGE: search_range <= cfg_data[RANGE_W-1:0];
        REG_WANTED_COUNT: wanted_count <= cfg_data[WANT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- distance pipeline ----
  assign cand_ready = (state == ST_INSERT) && !stat.final_inflight;

  knnsel_dist #(.IDW(IdW)) u_dist (
    .clk          (clk),
    .rst          (rst),
    .take         (cand_valid && cand_ready),
    .cand         (cand),
    .query_x      (query_x),
    .query_z      (query_z),
    .query_id     (query_id),
    .search_range (search_range),
    .stat         (stat),
    .out_id       (s3_id),
    .out_dist     (s3_dist)
  );

  // ---- insertion chain ----
  assign ctl.shift_left = load;
  assign ctl.cand_valid = stat.valid && stat.keep;
  // a lowered wanted count drops the tail only when the next item is handled
  assign ctl.trim       = stat.valid;

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    logic              lb, lv, rv;
    logic [IdW-1:0]    lid, rid;
    logic [DIST_W-1:0] ld, rd;

    if (i == 0) begin : g_head
      assign lb  = 1'b0;
      assign lv  = 1'b0;
      assign lid = '0;
      assign ld  = '0;
    end else begin : g_body
      assign lb  = cb[i-1];
      assign lv  = cv[i-1];
      assign lid = cid[i-1];
      assign ld  = cdist[i-1];
    end

    if (i == MAX_KEPT - 1) begin : g_tail
      assign rv  = 1'b0;
      assign rid = '0;
      assign rd  = '0;
    end else begin : g_inner
      assign rv  = cv[i+1];
      assign rid = cid[i+1];
      assign rd  = cdist[i+1];
    end

    knnsel_cell #(.IDW(IdW)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .enable      (32'(wanted_count) > i),
      .cand_id     (s3_id),
      .cand_dist   (s3_dist),
      .left_before (lb),
      .left_v      (lv),
      .left_id     (lid),
      .left_dist   (ld),
      .right_v     (rv),
      .right_id    (rid),
      .right_dist  (rd),
      .ahead       (cb[i]),
      .v           (cv[i]),
      .id          (cid[i]),
      .key_dist    (cdist[i])
    );
  end

  // ---- drain ----
  assign cv_pad = {1'b0, cv};
  assign load   = (state == ST_DRAIN) && (!nbr_valid || nbr_ready);
  assign last   = !cv_pad[1];

  always_comb begin
    nbr_next.neighbour_id      = cv[0] ? ID_W'(cid[0]) : '0;
    nbr_next.neighbour_dist_sq = cv[0] ? cdist[0] : '0;
    nbr_next.neighbour_rank    = cv[0] ? rank : '0;
    nbr_next.entry_valid       = cv[0];
    nbr_next.last_of_list      = last;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INSERT: if (stat.valid && stat.fin) state_next = ST_DRAIN;
      ST_DRAIN:  if (load && last) state_next = ST_INSERT;
      default:   state_next = ST_INSERT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INSERT;
      nbr_valid <= 1'b0;
      rank      <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        nbr_valid <= 1'b1;
        rank      <= last ? '0 : rank + 1'b1;
      end else if (nbr_ready) begin
        nbr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      nbr <= nbr_next;
    end
  end

  // ---- checks ----
  a_chain_packed: assert property (@(posedge clk) disable iff (rst)
    (cv & (cv + MAX_KEPT'(1))) == '0)
    else $error("chain valid bits are not a prefix");

  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    $fell(state == ST_DRAIN) |-> (cv == '0))
    else $error("list not empty after drain");

  a_no_insert_in_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> !stat.valid)
    else $error("candidate reached the chain during drain");

  a_result_from_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(nbr_valid) |-> $past(state == ST_DRAIN))
    else $error("result raised outside drain");

endmodule

// ===== rtl/knnsel_dist.sv =====
// Three-stage distance pipeline: coordinate differences, squares, sum and
// range test. Depends on knnsel_pkg.
module knnsel_dist import knnsel_pkg::*; #(
  parameter int IDW = DEF_ID_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  cand_t                     cand,
  input  logic signed [COORD_W-1:0] query_x,
  input  logic signed [COORD_W-1:0] query_z,
  input  logic [ID_W-1:0]           query_id,
  input  logic [RANGE_W-1:0]        search_range,
  output dist_stat_t                stat,
  output logic [IDW-1:0]            out_id,
  output logic [DIST_W-1:0]         out_dist
);

  // stage 1
  logic                     s1_v, s1_fin, s1_skip;
  logic [IDW-1:0]           s1_id;
  logic signed [DIFF_W-1:0] s1_dx, s1_dz;
  // stage 2
  logic                     s2_v, s2_fin, s2_skip;
  logic [IDW-1:0]           s2_id;
  logic [SQ_W-1:0]          s2_sqx, s2_sqz;
  logic [2*RANGE_W-1:0]     range_sq;
  // stage 3
  logic                     s3_v, s3_fin, s3_keep;
  logic [IDW-1:0]           s3_id;
  logic [DIST_W-1:0]        s3_dist;

  logic signed [2*DIFF_W-1:0] prod_x, prod_z;
  logic [SQ_W:0]              dist_sum;

  assign prod_x   = s1_dx * s1_dx;
  assign prod_z   = s1_dz * s1_dz;
  assign dist_sum = {1'b0, s2_sqx} + {1'b0, s2_sqz};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= take;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_fin  <= cand.final_candidate;
    s1_id   <= cand.candidate_id[IDW-1:0];
    s1_skip <= (cand.candidate_id[IDW-1:0] == query_id[IDW-1:0]);
    s1_dx   <= DIFF_W'(cand.candidate_x) - DIFF_W'(query_x);
    s1_dz   <= DIFF_W'(cand.candidate_z) - DIFF_W'(query_z);

    s2_fin   <= s1_fin;
    s2_id    <= s1_id;
    s2_skip  <= s1_skip;
    s2_sqx   <= prod_x[SQ_W-1:0];
    s2_sqz   <= prod_z[SQ_W-1:0];
    // follows the range register every cycle; an item is registered in s1 and s2 first
    range_sq <= search_range * search_range;

    s3_fin  <= s2_fin;
    s3_id   <= s2_id;
    s3_keep <= !s2_skip && (dist_sum <= (SQ_W+1)'(range_sq));
    s3_dist <= dist_sum[DIST_W-1:0];
  end

  assign stat.valid          = s3_v;
  assign stat.keep           = s3_keep;
  assign stat.fin            = s3_fin;
  assign stat.final_inflight = (s1_v && s1_fin) || (s2_v && s2_fin) || (s3_v && s3_fin);
  assign out_id              = s3_id;
  assign out_dist            = s3_dist;

endmodule

// ===== rtl/knnsel_cell.sv =====
// One slot of the sorted insertion chain: holds an entry and compares it with
// the broadcast candidate. Depends on knnsel_pkg.
module knnsel_cell import knnsel_pkg::*; #(
  parameter int IDW = DEF_ID_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic              enable,      // slot lies below the wanted count
  input  logic [IDW-1:0]    cand_id,
  input  logic [DIST_W-1:0] cand_dist,
  input  logic              left_before, // candidate sorts before the left entry
  input  logic              left_v,
  input  logic [IDW-1:0]    left_id,
  input  logic [DIST_W-1:0] left_dist,
  input  logic              right_v,
  input  logic [IDW-1:0]    right_id,
  input  logic [DIST_W-1:0] right_dist,
  output logic              ahead,
  output logic              v,
  output logic [IDW-1:0]    id,
  output logic [DIST_W-1:0] key_dist
);

  logic              v_next;
  logic [IDW-1:0]    id_next;
  logic [DIST_W-1:0] dist_next;

  // an empty slot sorts after everything; equal keys put the lower id first
  assign ahead = ctl.cand_valid &&
                 (!v || (cand_dist < key_dist) ||
                  ((cand_dist == key_dist) && (cand_id < id)));

  always_comb begin
    priority if (ctl.shift_left) begin
      v_next    = right_v;
      id_next   = right_id;
      dist_next = right_dist;
    end else if (left_before) begin
      v_next    = left_v;
      id_next   = left_id;
      dist_next = left_dist;
    end else if (ahead) begin
      v_next    = 1'b1;
      id_next   = cand_id;
      dist_next = cand_dist;
    end else begin
      v_next    = v;
      id_next   = id;
      dist_next = key_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else begin
      v <= v_next && (enable || !ctl.trim);
    end
  end

  always_ff @(posedge clk) begin
    id       <= id_next;
    key_dist <= dist_next;
  end

endmodule
